// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/bmhq_pkg.sv =====
`default_nettype none
package bmhq_pkg;
    localparam int Capacity = 1024;
    localparam int AddrW = $clog2(Capacity);
    localparam int CountW = $clog2(Capacity + 1);
    localparam int KeyW = 32;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_EXTRACT = 3'd1;
    localparam logic [2:0] REQ_DECREASE = 3'd2;
    localparam logic [2:0] REQ_HEAPIFY = 3'd3;
    localparam logic [2:0] REQ_READ = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Datapath operations chosen by the controller each cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // latch request and its status, set start position
        OP_RD_A,      // read entry at pos
        OP_RD_B,      // read parent or left child
        OP_RD_C,      // read right child
        OP_RD_CUR,    // take entry at pos as the moving key, read left child
        OP_WR_CUR,    // write cur key at pos
        OP_UP_STEP,   // compare with parent, swap or finish
        OP_DN_STEP,   // compare children, swap or finish
        OP_EXT_ROOT,  // capture root, read last entry, shrink
        OP_EXT_MOVE,  // write last to root
        OP_INS,       // append key, grow
        OP_RESULT     // load result register
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       full;
        logic       empty;
        logic       range_bad;
        logic       up_swap;
        logic       dn_swap;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== design/bmhq_datapath.sv =====
`default_nettype none
module bmhq_datapath
    import bmhq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    input  wire logic [2:0]        in_req,
    input  wire logic [AddrW-1:0]  in_index,
    input  wire logic [KeyW-1:0]   in_key,
    output logic [KeyW-1:0]        res_value,
    output logic [1:0]             res_status,
    output logic [CountW-1:0]      res_count
);
    logic [KeyW-1:0] mem [Capacity];
    logic [KeyW-1:0] rdata;
    logic [AddrW-1:0] raddr;
    logic rd_en;
    logic [AddrW-1:0] waddr;
    logic [KeyW-1:0] wdata;
    logic we;

    logic [2:0] req_reg;
    logic [AddrW-1:0] idx_reg;
    logic [KeyW-1:0] key_reg;
    logic [CountW-1:0] count_reg, count_next;
    logic [AddrW-1:0] pos_reg, pos_next;
    logic [KeyW-1:0] cur_reg, cur_next;     // key being sifted
    logic [KeyW-1:0] b_reg, b_next;         // left child
    logic [KeyW-1:0] val_reg, val_next;     // extracted root
    logic [1:0] st_reg, st_next;            // status decided at accept
    logic [KeyW-1:0] res_value_reg, res_value_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [CountW-1:0] res_count_reg, res_count_next;

    logic [AddrW-1:0] parent;
    logic [CountW:0] left_w, right_w;
    logic left_ok, right_ok, pick_right;
    logic [KeyW-1:0] best_key;
    logic [AddrW-1:0] best_pos;
    logic in_range_bad;
    logic up_mode;
    logic [1:0] st_calc;

    assign parent = (pos_reg - AddrW'(1)) >> 1;
    assign left_w = {1'b0, pos_reg, 1'b1};
    assign right_w = left_w + (CountW+1)'(1);
    assign left_ok = left_w < {1'b0, count_reg};
    assign right_ok = right_w < {1'b0, count_reg};
    assign pick_right = right_ok && ($signed(rdata) < $signed(b_reg));
    assign best_key = pick_right ? rdata : b_reg;
    assign best_pos = pick_right ? right_w[AddrW-1:0] : left_w[AddrW-1:0];
    assign in_range_bad = {1'b0, in_index} >= count_reg;
    assign up_mode = (req_reg == REQ_INSERT) || (req_reg == REQ_DECREASE);

    // status of the incoming beat, judged against the count before it runs
    always_comb
    begin
        st_calc = ST_OK;
        unique case (in_req)
            REQ_INSERT: if (stat.full) st_calc = ST_FULL;
            REQ_EXTRACT: if (stat.empty) st_calc = ST_EMPTY;
            REQ_DECREASE, REQ_HEAPIFY, REQ_READ: if (in_range_bad) st_calc = ST_RANGE;
            default: st_calc = ST_OK;
        endcase
    end

    assign stat.req = req_reg;
    assign stat.full = count_reg == CountW'(Capacity);
    assign stat.empty = count_reg == '0;
    assign stat.range_bad = {1'b0, idx_reg} >= count_reg;
    assign stat.up_swap = (pos_reg != '0) && ($signed(cur_reg) < $signed(rdata));
    assign stat.dn_swap = left_ok && ($signed(best_key) < $signed(cur_reg));

    always_comb
    begin
        count_next = count_reg;
        pos_next = pos_reg;
        cur_next = cur_reg;
        b_next = b_reg;
        val_next = val_reg;
        st_next = st_reg;
        res_value_next = res_value_reg;
        res_status_next = res_status_reg;
        res_count_next = res_count_reg;
        raddr = pos_reg;
        rd_en = 1'b0;
        waddr = pos_reg;
        wdata = cur_reg;
        we = 1'b0;
        unique case (cmd.op)
            OP_NONE: ;
            OP_LOAD:
            begin
                pos_next = (in_req == REQ_EXTRACT) ? '0 : in_index;
                cur_next = in_key;
                st_next = st_calc;
            end
            OP_RD_A: begin raddr = pos_reg; rd_en = 1'b1; end
            OP_RD_B:
            begin
                raddr = up_mode ? parent : left_w[AddrW-1:0];
                rd_en = 1'b1;
            end
            OP_RD_C:
            begin
                b_next = rdata;
                raddr = right_w[AddrW-1:0];
                rd_en = 1'b1;
            end
            OP_RD_CUR:
            begin
                cur_next = rdata;
                raddr = left_w[AddrW-1:0];
                rd_en = 1'b1;
            end
            OP_WR_CUR: begin we = 1'b1; end
            OP_UP_STEP:
            begin
                if (stat.up_swap)
                begin
                    we = 1'b1;
                    wdata = rdata;
                    pos_next = parent;
                end
            end
            OP_DN_STEP:
            begin
                if (stat.dn_swap)
                begin
                    we = 1'b1;
                    wdata = best_key;
                    pos_next = best_pos;
                end
            end
            OP_EXT_ROOT:
            begin
                val_next = rdata;
                raddr = AddrW'(count_reg - CountW'(1));
                rd_en = 1'b1;
                count_next = count_reg - CountW'(1);
                pos_next = '0;
            end
            OP_EXT_MOVE:
            begin
                cur_next = rdata;
                waddr = '0;
                wdata = rdata;
                we = 1'b1;
            end
            OP_INS:
            begin
                pos_next = AddrW'(count_reg);
                cur_next = key_reg;
                waddr = AddrW'(count_reg);
                wdata = key_reg;
                we = 1'b1;
                count_next = count_reg + CountW'(1);
            end
            OP_RESULT:
            begin
                res_status_next = st_reg;
                res_count_next = count_reg;
                res_value_next = '0;
                if (st_reg == ST_EMPTY)
                    res_value_next = '1;
                else if (st_reg == ST_OK && req_reg == REQ_EXTRACT)
                    res_value_next = val_reg;
                else if (st_reg == ST_OK && req_reg == REQ_READ)
                    res_value_next = rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (rd_en)
            rdata <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            req_reg <= in_req;
            idx_reg <= in_index;
            key_reg <= in_key;
        end
        pos_reg <= pos_next;
        cur_reg <= cur_next;
        b_reg <= b_next;
        val_reg <= val_next;
        st_reg <= st_next;
        res_value_reg <= res_value_next;
        res_status_reg <= res_status_next;
        res_count_reg <= res_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign res_value = res_value_reg;
    assign res_status = res_status_reg;
    assign res_count = res_count_reg;
endmodule
`default_nettype wire

// ===== design/bmhq_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     valid,
    output logic          ready,
    output logic          result_valid,
    input  wire logic     result_ready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DECODE = 14'b00000000000010,
        S_RDA    = 14'b00000000000100,
        S_RDB    = 14'b00000000001000,
        S_RDC    = 14'b00000000010000,
        S_CUR    = 14'b00000000100000,
        S_UP     = 14'b00000001000000,
        S_DN     = 14'b00000010000000,
        S_EXT    = 14'b00000100000000,
        S_EXTMV  = 14'b00001000000000,
        S_EXTWR  = 14'b00010000000000,
        S_FIN    = 14'b00100000000000,
        S_OUT    = 14'b01000000000000,
        S_WAIT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic up_mode;

    assign up_mode = stat.req == REQ_INSERT || stat.req == REQ_DECREASE;
    assign ready = state_reg == S_IDLE;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (valid)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.req == REQ_INSERT)
                    state_next = stat.full ? S_FIN : S_RDA;
                else if (stat.req == REQ_EXTRACT)
                    state_next = stat.empty ? S_FIN : S_EXT;
                else if (stat.req == REQ_DECREASE || stat.req == REQ_HEAPIFY
                         || stat.req == REQ_READ)
                    state_next = stat.range_bad ? S_FIN : S_RDA;
                else
                    state_next = S_FIN;
            end
            S_RDA:
            begin
                priority if (stat.req == REQ_INSERT)
                begin
                    cmd.op = OP_INS;
                    state_next = S_RDB;
                end
                else if (stat.req == REQ_DECREASE)
                begin
                    cmd.op = OP_WR_CUR;
                    state_next = S_RDB;
                end
                else
                begin
                    cmd.op = OP_RD_A;
                    state_next = (stat.req == REQ_READ) ? S_FIN : S_CUR;
                end
            end
            S_CUR: begin cmd.op = OP_RD_CUR; state_next = S_RDC; end
            S_RDB:
            begin
                cmd.op = OP_RD_B;
                state_next = up_mode ? S_UP : S_RDC;
            end
            S_RDC: begin cmd.op = OP_RD_C; state_next = S_DN; end
            S_UP:
            begin
                cmd.op = OP_UP_STEP;
                state_next = stat.up_swap ? S_WAIT : S_FIN;
            end
            S_DN:
            begin
                cmd.op = OP_DN_STEP;
                state_next = stat.dn_swap ? S_WAIT : S_FIN;
            end
            S_WAIT:
            begin
                // write the moving key at its new position, then read again
                cmd.op = OP_WR_CUR;
                state_next = S_RDB;
            end
            S_EXT: begin cmd.op = OP_RD_A; state_next = S_EXTMV; end
            S_EXTMV: begin cmd.op = OP_EXT_ROOT; state_next = S_EXTWR; end
            S_EXTWR: begin cmd.op = OP_EXT_MOVE; state_next = S_RDB; end
            S_FIN: state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    cmd.op = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_load_after_accept, clk, rst_n, valid && ready, state_reg == S_DECODE)
    `ASSERT_IMPLY(a_onehot_state, clk, rst_n, 1'b1, $onehot(state_reg))
    `ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid)
endmodule
`default_nettype wire

// ===== design/binary_min_heap_queue_unit.sv =====
// Channel | Handshake                    | Fields
// request | valid / ready                | req_type, index, key_value
// result  | result_valid / result_ready  | result_value, status, entry_count
// One request at a time over a single-port heap memory with registered reads.
// A rejected or unknown beat goes straight to its result and a read does one memory
// read; insert and decrease sift the key up and heapify and extract sift it down, one
// level per compare-and-swap round; the deepest sift covers 10 levels, up or down.
// Reset clears the entry count and control; heap memory needs no clearing.
// The result register holds while result_ready is low; the next beat is taken
// meanwhile and stalls in its last cycle until the result register frees.
`default_nettype none
module binary_min_heap_queue_unit
    import bmhq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid,
    output logic                   ready,
    input  wire logic [2:0]        req_type,
    input  wire logic [AddrW-1:0]  index,
    input  wire logic [KeyW-1:0]   key_value,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic [KeyW-1:0]        result_value,
    output logic [1:0]             status,
    output logic [CountW-1:0]      entry_count
);
    dp_cmd_t cmd;
    dp_stat_t stat;

    bmhq_ctrl u_ctrl (
        .clk, .rst_n, .valid, .ready, .result_valid, .result_ready, .cmd, .stat
    );

    bmhq_datapath u_dp (
        .clk, .rst_n, .cmd, .stat,
        .in_req(req_type), .in_index(index), .in_key(key_value),
        .res_value(result_value), .res_status(status), .res_count(entry_count)
    );
endmodule
`default_nettype wire

// ===== dv/binary_min_heap_queue_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module binary_min_heap_queue_unit_tb
    import bmhq_pkg::*;
;
    localparam int CycleLimit = 1500000;
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST = 3'd7;

    typedef struct packed {
        logic [KeyW-1:0]   value;
        logic [1:0]        st;
        logic [CountW-1:0] count;
    } heap_result_t;

    logic              clk;
    logic              rst_n;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [AddrW-1:0]  index;
    logic [KeyW-1:0]   key_value;
    logic              result_valid;
    logic              result_ready;
    logic [KeyW-1:0]   result_value;
    logic [1:0]        status;
    logic [CountW-1:0] entry_count;

    logic [KeyW-1:0]   model_keys [Capacity];
    int unsigned       model_count;
    heap_result_t      pending_results [$];
    int                error_count;
    int                cycle_count;
    bit                quiet_mode;
    bit                hold_result;

    binary_min_heap_queue_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (valid),
        .ready        (ready),
        .req_type     (req_type),
        .index        (index),
        .key_value    (key_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_value (result_value),
        .status       (status),
        .entry_count  (entry_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic bit key_lt(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    task automatic swap_keys(int unsigned a, int unsigned b);
        logic [KeyW-1:0] t;
        t = model_keys[a];
        model_keys[a] = model_keys[b];
        model_keys[b] = t;
    endtask

    task automatic bubble_up(int unsigned pos);
        int unsigned p;
        while (pos > 0)
        begin
            p = (pos - 1) / 2;
            if (!key_lt(model_keys[pos], model_keys[p]))
                break;
            swap_keys(pos, p);
            pos = p;
        end
    endtask

    task automatic bubble_down(int unsigned pos);
        int unsigned best;
        int unsigned l;
        forever
        begin
            best = pos;
            l = 2 * pos + 1;
            if (l < model_count && key_lt(model_keys[l], model_keys[best]))
                best = l;
            if (l + 1 < model_count && key_lt(model_keys[l + 1], model_keys[best]))
                best = l + 1;
            if (best == pos)
                break;
            swap_keys(pos, best);
            pos = best;
        end
    endtask

    task automatic apply_heap_request(logic [2:0] rq, logic [AddrW-1:0] ix,
                                      logic [KeyW-1:0] k);
        heap_result_t r;
        r.value = '0;
        r.st = ST_OK;
        case (rq)
            REQ_INSERT:
                if (model_count >= Capacity)
                    r.st = ST_FULL;
                else
                begin
                    model_keys[model_count] = k;
                    model_count++;
                    bubble_up(model_count - 1);
                end
            REQ_EXTRACT:
                if (model_count == 0)
                begin
                    r.st = ST_EMPTY;
                    r.value = '1;
                end
                else
                begin
                    r.value = model_keys[0];
                    model_count--;
                    model_keys[0] = model_keys[model_count];
                    bubble_down(0);
                end
            REQ_DECREASE:
                if (ix >= model_count)
                    r.st = ST_RANGE;
                else
                begin
                    model_keys[ix] = k;
                    bubble_up(ix);
                end
            REQ_HEAPIFY:
                if (ix >= model_count)
                    r.st = ST_RANGE;
                else
                    bubble_down(ix);
            REQ_READ:
                if (ix >= model_count)
                    r.st = ST_RANGE;
                else
                    r.value = model_keys[ix];
            default: ;
        endcase
        r.count = model_count[CountW-1:0];
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [KeyW-1:0] got, logic [KeyW-1:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic bit idle_now();
        return !quiet_mode && ($urandom_range(99) < 25);
    endfunction

    // Send one beat; idle randomly first, then hold valid until accepted.
    task automatic send_request(logic [2:0] rq, logic [AddrW-1:0] ix, logic [KeyW-1:0] k);
        do
            @(negedge clk);
        while (idle_now());
        valid <= 1'b1;
        req_type <= rq;
        index <= ix;
        key_value <= k;
        apply_heap_request(rq, ix, k);
        @(posedge clk);
        while (!ready)
            @(posedge clk);
        @(negedge clk);
        valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic logic [KeyW-1:0] random_key();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [AddrW-1:0] random_index();
        if (model_count != 0 && $urandom_range(9) < 8)
            return AddrW'($urandom_range(model_count - 1));
        return AddrW'($urandom);
    endfunction

    function automatic logic [2:0] random_spare();
        return 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
    endfunction

    // Result side: random stalls unless held off by the pressure test.
    always @(negedge clk)
        result_ready <= !hold_result && !idle_now();

    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.value)
                    report_mismatch("result_value", result_value, want.value);
                if (status !== want.st)
                    report_mismatch("status", KeyW'(status), KeyW'(want.st));
                if (entry_count !== want.count)
                    report_mismatch("entry_count", KeyW'(entry_count), KeyW'(want.count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_empty_and_range();
        send_request(REQ_EXTRACT, '0, '0);
        send_request(REQ_READ, '0, '0);
        send_request(REQ_HEAPIFY, 10'h3ff, '0);
        send_request(REQ_DECREASE, 10'd5, 32'h1234);
        send_request(REQ_SPARE_FIRST, 10'h3ff, 32'hffff_ffff);
        send_request(REQ_SPARE_LAST, '0, '0);
    endtask

    task automatic test_basic_ops();
        send_request(REQ_INSERT, '0, 32'h7fff_ffff);
        send_request(REQ_INSERT, '0, 32'h8000_0000);
        send_request(REQ_INSERT, 10'h3ff, 32'd5);
        send_request(REQ_INSERT, '0, 32'd5);
        send_request(REQ_INSERT, '0, 32'hffff_ffff);
        send_request(REQ_READ, '0, '0);
        send_request(REQ_READ, 10'd4, '0);
        send_request(REQ_READ, 10'd5, '0);
        send_request(REQ_DECREASE, 10'd3, 32'h8000_0000);
        // Raise a key: sifts up only, order below left broken.
        send_request(REQ_DECREASE, '0, 32'h7fff_fff0);
        send_request(REQ_HEAPIFY, '0, '0);
        send_request(REQ_EXTRACT, '0, '0);
        send_request(REQ_EXTRACT, '0, '0);
        send_request(random_spare(), 10'd1, 32'd9);
        wait_drained();
    endtask

    task automatic test_full_heap();
        while (model_count < Capacity)
            send_request(REQ_INSERT, '0, $urandom_range(255));
        send_request(REQ_INSERT, '0, 32'd1);
        send_request(REQ_READ, 10'h3ff, '0);
        send_request(REQ_HEAPIFY, 10'h3ff, '0);
        repeat (40) send_request(REQ_EXTRACT, '0, '0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_result = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_result = 1'b0;
            end
            repeat (12) send_request(REQ_INSERT, '0, random_key());
        join
        wait_drained();
    endtask

    task automatic test_random_mix(int n);
        int kind;
        for (int i = 0; i < n; i++)
        begin
            quiet_mode = (i >= n / 2 && i < n / 2 + 150);
            kind = $urandom_range(99);
            if (kind < 35)
                send_request(REQ_INSERT, random_index(), random_key());
            else if (kind < 60)
                send_request(REQ_EXTRACT, random_index(), random_key());
            else if (kind < 72)
                send_request(REQ_DECREASE, random_index(), random_key());
            else if (kind < 82)
                send_request(REQ_HEAPIFY, random_index(), random_key());
            else if (kind < 97)
                send_request(REQ_READ, random_index(), random_key());
            else
                send_request(random_spare(), AddrW'($urandom), $urandom);
        end
        quiet_mode = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        valid = 1'b0;
        req_type = '0;
        index = '0;
        key_value = '0;
        result_ready = 1'b0;
        model_count = 0;
        error_count = 0;
        cycle_count = 0;
        quiet_mode = 1'b0;
        hold_result = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_and_range();
        test_basic_ops();
        test_backpressure();
        test_random_mix(900);
        test_full_heap();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
